/* sv/mlpf_pkg.sv */
`default_nettype none

package mlpf_pkg;

   // Fixed widths of the channel fields
   localparam int PRIO_FIELD_W  = 4;
   localparam int TAG_FIELD_W   = 16;
   localparam int COUNT_FIELD_W = 9;

   typedef enum logic [0:0] {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                    operation;
      logic [PRIO_FIELD_W-1:0]   priority_req;
      logic [TAG_FIELD_W-1:0]    item_tag;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [TAG_FIELD_W-1:0]    out_tag;
      logic [PRIO_FIELD_W-1:0]   out_priority;
      logic [COUNT_FIELD_W-1:0]  total_count;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/multilevel_priority_fifo.sv */
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  mlpf_pkg::req_type (operation, priority_req, item_tag)
// rsp      out        rsp_valid/rsp_stall  mlpf_pkg::rsp_type (status, out_tag, out_priority,
//                                          total_count)
//
// One item per cycle sustained while the result side is not stalled; each item passes the
// input register, then the result register together with the registered tag RAM read.
// The level pick, the ring pointer step and the count update all settle in the input
// register, so the next item sees the updated state. Synchronous reset empties every level.
// A stalled result holds; one more item waits in the input register before req_stall rises.

`default_nettype none

module multilevel_priority_fifo #(
   parameter int LEVELS      = 16,
   parameter int LEVEL_DEPTH = 16,
   parameter int TAG_BITS    = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mlpf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mlpf_pkg::rsp_type      rsp_data
);

   localparam int LVL_W   = $clog2(LEVELS);
   localparam int PTR_W   = $clog2(LEVEL_DEPTH);
   localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
   localparam int ENTRIES = LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int TOT_W   = $clog2(ENTRIES + 1);
   localparam int STORE_W = (TAG_BITS < mlpf_pkg::TAG_FIELD_W) ? TAG_BITS
                                                               : mlpf_pkg::TAG_FIELD_W;

   // input register
   logic              in_valid_ff;
   mlpf_pkg::req_type in_ff;

   // per-level ring state
   logic [PTR_W-1:0]  head_ff [LEVELS];
   logic [PTR_W-1:0]  tail_ff [LEVELS];
   logic [CNT_W-1:0]  cnt_ff  [LEVELS];
   logic [TOT_W-1:0]  total_ff;

   // result register
   logic              rsp_valid_ff;
   mlpf_pkg::rsp_type rsp_meta_ff;
   logic              rsp_hit_ff;

   logic              adv;
   logic              is_deq;
   logic [LEVELS-1:0] nonempty;
   logic              found;
   logic [LVL_W-1:0]  enq_lv;
   logic [LVL_W-1:0]  deq_lv;
   logic [LVL_W-1:0]  sel_lv;
   logic [CNT_W-1:0]  sel_cnt;
   logic              full;
   logic              enq_ok;
   logic              deq_ok;
   logic [PTR_W-1:0]  pos;
   logic [PTR_W-1:0]  pos_in;
   logic [CNT_W-1:0]  cnt_in;
   logic [TOT_W-1:0]  total_in;
   logic [ADDR_W-1:0] ram_addr;
   logic [STORE_W-1:0] rd_tag;
   mlpf_pkg::rsp_type rsp_meta_in;

   // stage 1 moves on whenever the result register is free or being drained
   assign adv       = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !adv;
   assign is_deq    = (in_ff.operation == mlpf_pkg::OP_DEQUEUE);

   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         nonempty[i] = (cnt_ff[i] != '0);
      end
   end

   assign found = |nonempty;

   // most urgent non-empty level
   always_comb begin
      deq_lv = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            deq_lv = LVL_W'(i);
         end
      end
   end

   // priorities past the last level land in the last level
   always_comb begin
      if (int'(in_ff.priority_req) >= LEVELS) begin
         enq_lv = LVL_W'(LEVELS - 1);
      end else begin
         enq_lv = LVL_W'(in_ff.priority_req);
      end
   end

   assign sel_lv  = is_deq ? deq_lv : enq_lv;
   assign sel_cnt = cnt_ff[sel_lv];
   assign full    = (sel_cnt == CNT_W'(LEVEL_DEPTH));
   assign enq_ok  = !is_deq && !full;
   assign deq_ok  = is_deq && found;

   assign pos    = is_deq ? head_ff[sel_lv] : tail_ff[sel_lv];
   assign pos_in = (pos == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : pos + 1'b1;
   assign cnt_in = deq_ok ? sel_cnt - 1'b1 : sel_cnt + 1'b1;

   always_comb begin
      total_in = total_ff;
      if (enq_ok) begin
         total_in = total_ff + 1'b1;
      end else if (deq_ok) begin
         total_in = total_ff - 1'b1;
      end
   end

   assign ram_addr = ADDR_W'(sel_lv) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(pos);

   always_comb begin
      rsp_meta_in              = '0;
      rsp_meta_in.total_count  = mlpf_pkg::COUNT_FIELD_W'(total_in);
      if (is_deq) begin
         if (found) begin
            rsp_meta_in.status       = mlpf_pkg::STATUS_DONE;
            rsp_meta_in.out_priority = mlpf_pkg::PRIO_FIELD_W'(deq_lv);
         end else begin
            rsp_meta_in.status = mlpf_pkg::STATUS_EMPTY;
         end
      end else if (full) begin
         rsp_meta_in.status = mlpf_pkg::STATUS_FULL;
      end else begin
         rsp_meta_in.status = mlpf_pkg::STATUS_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         total_ff <= '0;
      end else if (adv && (enq_ok || deq_ok)) begin
         if (deq_ok) begin
            head_ff[sel_lv] <= pos_in;
         end else begin
            tail_ff[sel_lv] <= pos_in;
         end
         cnt_ff[sel_lv] <= cnt_in;
         total_ff       <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_meta_ff <= rsp_meta_in;
         rsp_hit_ff  <= deq_ok;
      end
   end

   mlpf_tag_ram #(
      .DEPTH  (ENTRIES),
      .WIDTH  (STORE_W),
      .ADDR_W (ADDR_W)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (adv && enq_ok),
      .rd_en   (adv && deq_ok),
      .addr    (ram_addr),
      .wr_data (STORE_W'(in_ff.item_tag)),
      .rd_data (rd_tag)
   );

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data         = rsp_meta_ff;
      rsp_data.out_tag = rsp_hit_ff ? mlpf_pkg::TAG_FIELD_W'(rd_tag) : '0;
   end

`ifndef SYNTHESIS

   a_stall_only_when_blocked: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall)
   ) else $error("input stalled while result side is free");

   a_empty_means_zero_total: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == mlpf_pkg::STATUS_EMPTY) |-> (rsp_data.total_count == '0)
   ) else $error("empty dequeue reported with items queued");

   a_enqueue_bumps_total: assert property (
      @(posedge clock) disable iff (reset)
      (adv && enq_ok) |=> (total_ff == $past(total_ff) + 1'b1)
   ) else $error("total not incremented on enqueue");

   a_level_within_depth: assert property (
      @(posedge clock) disable iff (reset)
      in_valid_ff |-> (sel_cnt <= CNT_W'(LEVEL_DEPTH))
   ) else $error("level count beyond depth");

`endif

endmodule

`default_nettype wire

/* sv/mlpf_tag_ram.sv */
`default_nettype none

module mlpf_tag_ram #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sim/tb_multilevel_priority_fifo.sv */
`timescale 1ns / 100ps

module tb_multilevel_priority_fifo;

   localparam int PRIO_MAX = (1 << mlpf_pkg::PRIO_FIELD_W) - 1;

   // Predicts each result from the per-level rings and holds those still due.
   class level_queue_model;
      localparam int NUM_LEVELS  = 16;
      localparam int LEVEL_SLOTS = 16;

      logic [mlpf_pkg::TAG_FIELD_W-1:0] ring [NUM_LEVELS][LEVEL_SLOTS];
      int head [NUM_LEVELS];
      int tail [NUM_LEVELS];
      int fill [NUM_LEVELS];
      int total;
      mlpf_pkg::rsp_type pending_results[$];
      int error_count;

      function new();
         foreach (fill[lv]) begin
            head[lv] = 0;
            tail[lv] = 0;
            fill[lv] = 0;
         end
         total = 0;
         error_count = 0;
      endfunction

      function mlpf_pkg::rsp_type predict_result(mlpf_pkg::req_type r);
         mlpf_pkg::rsp_type res;
         int lv;
         res = '0;
         res.status = mlpf_pkg::STATUS_DONE;
         if (r.operation == mlpf_pkg::OP_ENQUEUE) begin
            // levels past the last one fold into the least urgent level
            lv = (r.priority_req >= NUM_LEVELS) ? NUM_LEVELS - 1 : int'(r.priority_req);
            if (fill[lv] >= LEVEL_SLOTS) begin
               res.status = mlpf_pkg::STATUS_FULL;
            end else begin
               ring[lv][tail[lv]] = r.item_tag;
               tail[lv] = (tail[lv] + 1) % LEVEL_SLOTS;
               fill[lv]++;
               total++;
            end
         end else begin
            lv = 0;
            while (lv < NUM_LEVELS && fill[lv] == 0) lv++;
            if (lv == NUM_LEVELS) begin
               res.status = mlpf_pkg::STATUS_EMPTY;
            end else begin
               res.out_tag = ring[lv][head[lv]];
               res.out_priority = lv[mlpf_pkg::PRIO_FIELD_W-1:0];
               head[lv] = (head[lv] + 1) % LEVEL_SLOTS;
               fill[lv]--;
               total--;
            end
         end
         res.total_count = total[mlpf_pkg::COUNT_FIELD_W-1:0];
         return res;
      endfunction

      function void accept_request(mlpf_pkg::req_type r);
         pending_results.push_back(predict_result(r));
      endfunction

      task report_mismatch(string what);
         $display("%0t ns: mismatch: %s", $realtime, what);
         error_count++;
      endtask

      task check_response(mlpf_pkg::rsp_type got);
         mlpf_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing outstanding");
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.out_tag !== want.out_tag)
            report_mismatch($sformatf("out_tag %h, want %h", got.out_tag, want.out_tag));
         if (got.out_priority !== want.out_priority)
            report_mismatch($sformatf("out_priority %0d, want %0d",
                                      got.out_priority, want.out_priority));
         if (got.total_count !== want.total_count)
            report_mismatch($sformatf("total_count %0d, want %0d",
                                      got.total_count, want.total_count));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mlpf_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mlpf_pkg::rsp_type rsp_data;

   level_queue_model sb = new();

   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;
   bit hold_rx = 1'b0;
   int stall_left = 0;

   multilevel_priority_fifo uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int idle_cycles(bit calm);
      return calm ? 0 : int'($urandom_range(0, 19));
   endfunction

   // result side: a fresh stall count after each transfer, plus the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            stall_left = idle_cycles(rx_calm);
         else if (stall_left > 0)
            stall_left--;
         rsp_stall <= (stall_left > 0) || hold_rx;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.accept_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   // valid stays high after a transfer when the next item follows with no gap
   task automatic send_request(input mlpf_pkg::op_type op,
                               input logic [mlpf_pkg::PRIO_FIELD_W-1:0] prio,
                               input logic [mlpf_pkg::TAG_FIELD_W-1:0] tag);
      mlpf_pkg::req_type r;
      int gap;
      r.operation = op;
      r.priority_req = prio;
      r.item_tag = tag;
      gap = idle_cycles(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
   endtask

   task automatic run_phase(int count, int enq_pct, int prio_hi);
      mlpf_pkg::op_type op;
      logic [mlpf_pkg::TAG_FIELD_W-1:0] tag;
      for (int i = 0; i < count; i++) begin
         if (i > 0 && i % 25 == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
         end
         op = ($urandom_range(0, 99) < enq_pct) ? mlpf_pkg::OP_ENQUEUE : mlpf_pkg::OP_DEQUEUE;
         case ($urandom_range(0, 15))
            0: tag = '0;
            1: tag = '1;
            default: tag = mlpf_pkg::TAG_FIELD_W'($urandom);
         endcase
         send_request(op, mlpf_pkg::PRIO_FIELD_W'($urandom_range(0, prio_hi)), tag);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue, extremes of priority and tag, urgency order
      send_request(mlpf_pkg::OP_DEQUEUE, mlpf_pkg::PRIO_FIELD_W'($urandom),
                   mlpf_pkg::TAG_FIELD_W'($urandom));
      send_request(mlpf_pkg::OP_ENQUEUE, mlpf_pkg::PRIO_FIELD_W'(PRIO_MAX), '1);
      send_request(mlpf_pkg::OP_ENQUEUE, mlpf_pkg::PRIO_FIELD_W'(0), '0);
      send_request(mlpf_pkg::OP_ENQUEUE, mlpf_pkg::PRIO_FIELD_W'(7), 16'ha5a5);
      repeat (3) send_request(mlpf_pkg::OP_DEQUEUE, mlpf_pkg::PRIO_FIELD_W'($urandom),
                              mlpf_pkg::TAG_FIELD_W'($urandom));
      // fill one level, then an enqueue to it is refused
      for (int i = 0; i < 17; i++)
         send_request(mlpf_pkg::OP_ENQUEUE, mlpf_pkg::PRIO_FIELD_W'(3),
                      16'h3000 + i[mlpf_pkg::TAG_FIELD_W-1:0]);
      send_request(mlpf_pkg::OP_DEQUEUE, mlpf_pkg::PRIO_FIELD_W'($urandom),
                   mlpf_pkg::TAG_FIELD_W'($urandom));
      drain_wait();

      // receiver holds off while the sender keeps offering transfers
      tx_calm = 1'b1;
      fork
         begin
            hold_rx <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rx <= 1'b0;
         end
         run_phase(40, 50, PRIO_MAX);
      join
      drain_wait();

      tx_calm = 1'b0;
      rx_calm <= 1'b0;
      run_phase(60, 50, PRIO_MAX);
      run_phase(60, 50, 1);
      run_phase(200, 90, PRIO_MAX);
      run_phase(180, 15, PRIO_MAX);

      drain_wait();
      repeat (8) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
sv/mlpf_pkg.sv
sv/mlpf_tag_ram.sv
sv/multilevel_priority_fifo.sv
sim/tb_multilevel_priority_fifo.sv
